FILE: rtl/sha256_byte_stream_hasher_assert.svh
// assertion macros for the sha-256 byte stream hasher
// used by shabsh_core and the top level, no other dependencies
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SHABSH_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SHABSH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/shabsh_pkg.sv
// shared types, constants and round functions for the sha-256 byte stream hasher
// no dependencies; used by shabsh_core and sha256_byte_stream_hasher
package shabsh_pkg;

  // request codes
  localparam logic REQ_ABSORB = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  // padding and block geometry
  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;
  localparam logic [5:0] FILL_LAST  = 6'd63;
  localparam logic [3:0] LEN_BYTES  = 4'd8;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [2:0] WORD_LAST  = 3'd7;

  // round constants
  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // initial hash value
  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMP,
    ST_PAD,
    ST_OUT
  } state_t;

  // requests from the sequencer to the compression unit
  typedef struct packed {
    logic       push;
    logic [7:0] data;
    logic       blk_end;
    logic       rotate;
    logic       reinit;
  } core_ctrl_t;

  // status back from the compression unit
  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] head_word;
  } core_sts_t;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    small_sig0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    small_sig1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

endpackage

FILE: rtl/shabsh_core.sv
// sha-256 compression unit: block shift line, rolling schedule, one round per cycle
// depends on shabsh_pkg and sha256_byte_stream_hasher_assert.svh
`include "sha256_byte_stream_hasher_assert.svh"

module shabsh_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  shabsh_pkg::core_ctrl_t ctrl,
  output shabsh_pkg::core_sts_t  sts
);

  logic [511:0] blk_r;
  logic [31:0]  wv_r [8];
  logic [31:0]  h_r  [8];
  logic [5:0]   rnd_r;
  logic         run_r;
  logic         add_r;

  logic [31:0] x0, x1, x9, x14;
  logic [31:0] w_new, t1, t2, ch, maj;

  // schedule window taps, word 0 is the current round's word
  assign x0  = blk_r[511:480];
  assign x1  = blk_r[479:448];
  assign x9  = blk_r[223:192];
  assign x14 = blk_r[63:32];

  // shared round datapath
  always_comb begin
    w_new = shabsh_pkg::small_sig1(x14) + x9 + shabsh_pkg::small_sig0(x1) + x0;
    ch    = (wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6]);
    maj   = (wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]);
    t1    = wv_r[7] + shabsh_pkg::big_sig1(wv_r[4]) + ch + shabsh_pkg::K_TAB[rnd_r] + x0;
    t2    = shabsh_pkg::big_sig0(wv_r[0]) + maj;
  end

  // round sequencing and chaining value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      add_r <= 1'b0;
      rnd_r <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= shabsh_pkg::H_INIT[i];
    end else begin
      add_r <= run_r && (rnd_r == shabsh_pkg::ROUND_LAST);
      if (ctrl.push && ctrl.blk_end) begin
        run_r <= 1'b1;
        rnd_r <= '0;
      end else if (run_r) begin
        rnd_r <= rnd_r + 6'd1;
        if (rnd_r == shabsh_pkg::ROUND_LAST) run_r <= 1'b0;
      end
      if (ctrl.reinit) begin
        for (int i = 0; i < 8; i++) h_r[i] <= shabsh_pkg::H_INIT[i];
      end else if (add_r) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + wv_r[i];
      end else if (ctrl.rotate) begin
        for (int i = 0; i < 7; i++) h_r[i] <= h_r[i + 1];
        h_r[7] <= h_r[0];
      end
    end
  end

  // block bytes and working variables
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      blk_r <= {blk_r[503:0], ctrl.data};
    end else if (run_r) begin
      blk_r <= {blk_r[479:0], w_new};
    end
    if (ctrl.push && ctrl.blk_end) begin
      for (int i = 0; i < 8; i++) wv_r[i] <= h_r[i];
    end else if (run_r) begin
      wv_r[0] <= t1 + t2;
      wv_r[1] <= wv_r[0];
      wv_r[2] <= wv_r[1];
      wv_r[3] <= wv_r[2];
      wv_r[4] <= wv_r[3] + t1;
      wv_r[5] <= wv_r[4];
      wv_r[6] <= wv_r[5];
      wv_r[7] <= wv_r[6];
    end
  end

  assign sts.busy      = run_r | add_r;
  assign sts.done      = add_r;
  assign sts.head_word = h_r[0];

  // checks
  `SHABSH_ASSERT_NOW(a_phase_excl, clk, rst_n, 1'b1, $onehot0({run_r, add_r}), "round and add overlap")
  `SHABSH_ASSERT_NOW(a_no_push_busy, clk, rst_n, ctrl.push, !(run_r | add_r), "byte pushed during compression")
  `SHABSH_ASSERT_NEXT(a_add_after_last, clk, rst_n, run_r && (rnd_r == shabsh_pkg::ROUND_LAST), add_r && !run_r, "add does not follow last round")

endmodule

FILE: rtl/sha256_byte_stream_hasher.sv
// Streaming SHA-256 hasher. An absorb request pushes its byte into the block; the 64th byte of a block
// starts a compression (64 rounds in the shared round unit, then one chaining add).
// A finish request pushes padding one byte a cycle between its one or two compressions, then shows
// eight digest words, one per cycle when not stalled. No request is taken meanwhile.
// Synchronous active-low reset loads the initial hash value and clears all counts.
// Depends on shabsh_pkg, shabsh_core and sha256_byte_stream_hasher_assert.svh.
`include "sha256_byte_stream_hasher_assert.svh"

module sha256_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  shabsh_pkg::state_t     state_r, state_nxt;
  logic                   fin_r, fin_nxt;
  logic [5:0]             fill_r, fill_nxt;
  logic [3:0]             len_cnt_r, len_cnt_nxt;
  logic [63:0]            byte_cnt_r, byte_cnt_nxt;
  logic [2:0]             word_idx_r, word_idx_nxt;
  shabsh_pkg::core_ctrl_t core_ctrl;
  shabsh_pkg::core_sts_t  core_sts;

  // compression unit
  shabsh_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (core_ctrl),
    .sts   (core_sts)
  );

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= shabsh_pkg::ST_IDLE;
      fin_r      <= 1'b0;
      fill_r     <= '0;
      len_cnt_r  <= '0;
      byte_cnt_r <= '0;
      word_idx_r <= '0;
    end else begin
      state_r    <= state_nxt;
      fin_r      <= fin_nxt;
      fill_r     <= fill_nxt;
      len_cnt_r  <= len_cnt_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      word_idx_r <= word_idx_nxt;
    end
  end

  // sequencer: absorb, padding, compression wait, digest output
  always_comb begin
    state_nxt    = state_r;
    fin_nxt      = fin_r;
    fill_nxt     = fill_r;
    len_cnt_nxt  = len_cnt_r;
    byte_cnt_nxt = byte_cnt_r;
    word_idx_nxt = word_idx_r;
    core_ctrl    = '0;
    unique case (state_r)
      shabsh_pkg::ST_IDLE: begin
        if (in_valid) begin
          core_ctrl.push    = 1'b1;
          core_ctrl.blk_end = (fill_r == shabsh_pkg::FILL_LAST);
          fill_nxt          = fill_r + 6'd1;
          if (in_req_type == shabsh_pkg::REQ_ABSORB) begin
            core_ctrl.data = in_data_byte;
            byte_cnt_nxt   = byte_cnt_r + 64'd1;
            if (core_ctrl.blk_end) state_nxt = shabsh_pkg::ST_COMP;
          end else begin
            // finish: marker byte now, byte count turned into bit length
            core_ctrl.data = shabsh_pkg::PAD_BYTE;
            fin_nxt        = 1'b1;
            byte_cnt_nxt   = {byte_cnt_r[60:0], 3'b000};
            state_nxt      = core_ctrl.blk_end ? shabsh_pkg::ST_COMP : shabsh_pkg::ST_PAD;
          end
        end
      end
      shabsh_pkg::ST_PAD: begin
        core_ctrl.push    = 1'b1;
        core_ctrl.blk_end = (fill_r == shabsh_pkg::FILL_LAST);
        fill_nxt          = fill_r + 6'd1;
        // zeros up to the length field, then the bit length msb first
        if ((len_cnt_r != 4'd0) || (fill_r == shabsh_pkg::LEN_OFFSET)) begin
          core_ctrl.data = byte_cnt_r[63:56];
          byte_cnt_nxt   = {byte_cnt_r[55:0], 8'h00};
          len_cnt_nxt    = len_cnt_r + 4'd1;
        end else begin
          core_ctrl.data = 8'h00;
        end
        if (core_ctrl.blk_end) state_nxt = shabsh_pkg::ST_COMP;
      end
      shabsh_pkg::ST_COMP: begin
        if (core_sts.done) begin
          if (!fin_r) begin
            state_nxt = shabsh_pkg::ST_IDLE;
          end else if (len_cnt_r == shabsh_pkg::LEN_BYTES) begin
            state_nxt = shabsh_pkg::ST_OUT;
          end else begin
            state_nxt = shabsh_pkg::ST_PAD;
          end
        end
      end
      shabsh_pkg::ST_OUT: begin
        if (!out_stall) begin
          word_idx_nxt = word_idx_r + 3'd1;
          if (word_idx_r == shabsh_pkg::WORD_LAST) begin
            // back to reset state for the next message
            core_ctrl.reinit = 1'b1;
            state_nxt        = shabsh_pkg::ST_IDLE;
            fin_nxt          = 1'b0;
            len_cnt_nxt      = '0;
            byte_cnt_nxt     = '0;
            fill_nxt         = '0;
          end else begin
            core_ctrl.rotate = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = shabsh_pkg::ST_IDLE;
      end
    endcase
  end

  // ports
  assign in_stall        = (state_r != shabsh_pkg::ST_IDLE);
  assign out_valid       = (state_r == shabsh_pkg::ST_OUT);
  assign out_digest_word = core_sts.head_word;
  assign out_word_index  = word_idx_r;
  assign out_last_word   = (word_idx_r == shabsh_pkg::WORD_LAST);

  // checks
  `SHABSH_ASSERT_NOW(a_out_block_empty, clk, rst_n, out_valid, fill_r == 6'd0, "digest shown with bytes in the block")
  `SHABSH_ASSERT_NOW(a_comp_busy, clk, rst_n, state_r == shabsh_pkg::ST_COMP, core_sts.busy, "waiting on an idle compression unit")
  `SHABSH_ASSERT_NOW(a_len_in_finish, clk, rst_n, len_cnt_r != 4'd0, fin_r, "length bytes outside a finish")
  `SHABSH_ASSERT_NEXT(a_clean_after_last, clk, rst_n, out_valid && !out_stall && out_last_word, (byte_cnt_r == 64'd0) && !fin_r && !out_valid, "state not cleared after digest")

endmodule

FILE: test/tb_sha256_byte_stream_hasher.sv
// self-checking testbench for sha256_byte_stream_hasher: byte and finish requests in,
// digest words out, checked against an in-bench sha-256 predictor held in a scoreboard class
// depends on shabsh_pkg and the hasher rtl only
module tb_sha256_byte_stream_hasher;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 100;
  localparam int RANDOM_REQS   = 105;
  localparam int RANDOM_MSGS   = 6;

  // sha-256 round constants
  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // sha-256 initial chaining value
  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct {
    logic [31:0] word;
    logic [2:0]  pos;
    logic        last;
  } digest_beat_t;

  // predictor state plus the queue of digest words still owed by the block
  class digest_scoreboard;
    logic [31:0]  chain [8];
    logic [7:0]   blk [64];
    logic [5:0]   fill;
    logic [63:0]  msg_bytes;
    digest_beat_t pending [$];
    int           errors;
    int           requests;
    int           messages;
    int           words_checked;

    function new();
      errors        = 0;
      requests      = 0;
      messages      = 0;
      words_checked = 0;
      restart();
    endfunction

    // back to the state of a fresh message
    function void restart();
      for (int i = 0; i < 8; i++) chain[i] = SHA_IV[i];
      for (int i = 0; i < 64; i++) blk[i] = 8'h00;
      fill      = '0;
      msg_bytes = '0;
    endfunction

    function logic [31:0] rotr(input logic [31:0] x, input int n);
      logic [63:0] twice;
      twice = {x, x} >> n;
      return twice[31:0];
    endfunction

    // one 64-round compression of the gathered block into the chaining value
    function void compress();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] s0, s1, t1, t2, ch, maj;
      for (int i = 0; i < 16; i++)
        w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 16; i < 64; i++) begin
        s0   = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
        s1   = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
        w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int r = 0; r < 64; r++) begin
        s1   = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
        ch   = (v[4] & v[5]) ^ (~v[4] & v[6]);
        t1   = v[7] + s1 + ch + SHA_K[r] + w[r];
        s0   = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
        maj  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
        t2   = s0 + maj;
        v[7] = v[6];
        v[6] = v[5];
        v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2];
        v[2] = v[1];
        v[1] = v[0];
        v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
    endfunction

    function void load_byte(input logic [7:0] b);
      blk[fill] = b;
      fill      = fill + 6'd1;
      if (fill == 6'd0) compress();
    endfunction

    // predict the effect of one accepted request
    function void note_request(input logic rt, input logic [7:0] db);
      logic [63:0]  bit_len;
      digest_beat_t beat;
      requests++;
      if (rt == shabsh_pkg::REQ_ABSORB) begin
        msg_bytes = msg_bytes + 64'd1;
        load_byte(db);
      end else begin
        messages++;
        bit_len = msg_bytes << 3;
        // padding marker, zeros up to the length field, then the big-endian bit count
        load_byte(8'h80);
        while (fill != 6'd56) load_byte(8'h00);
        for (int i = 0; i < 8; i++) load_byte(bit_len[63-8*i -: 8]);
        for (int i = 0; i < 8; i++) begin
          beat.word = chain[i];
          beat.pos  = 3'(i);
          beat.last = (i == 7);
          pending.insert(pending.size(), beat);
        end
        restart();
      end
    endfunction

    // compare one accepted digest word with the oldest one owed
    function void check_word(input logic [31:0] word, input logic [2:0] pos, input logic last);
      digest_beat_t want;
      words_checked++;
      if (pending.size() == 0) begin
        errors++;
        $error("digest word %h (index %0d) arrived with nothing expected", word, pos);
        return;
      end
      want = pending.pop_front();
      if (word !== want.word) begin
        errors++;
        $error("digest_word: expected %h, got %h", want.word, word);
      end
      if (pos !== want.pos) begin
        errors++;
        $error("word_index: expected %0d, got %0d", want.pos, pos);
      end
      if (last !== want.last) begin
        errors++;
        $error("last_word: expected %0b, got %0b", want.last, last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_req_type;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  digest_scoreboard sb;
  int  cycles     = 0;
  bit  tx_calm    = 1'b0;
  bit  rx_calm    = 1'b0;
  int  rx_hold    = 0;
  int  rx_seen    = 0;

  sha256_byte_stream_hasher uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  // clock
  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // digest word monitor
  always @(posedge clk) begin
    if (rst_n && sb != null && out_valid && !out_stall)
      sb.check_word(out_digest_word, out_word_index, out_last_word);
  end

  // result side stall: a fresh hold drawn after every accepted word
  always @(negedge clk) begin
    if (sb != null && sb.words_checked != rx_seen) begin
      rx_seen = sb.words_checked;
      if (rx_seen % 8 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      rx_hold = rx_calm ? 0 : $urandom_range(0, 15);
    end
    if (rx_hold > 0) begin
      out_stall = 1'b1;
      rx_hold--;
    end else begin
      out_stall = 1'b0;
    end
  end

  // present one request after a random gap and hold it until taken
  task automatic send_request(input logic rt, input logic [7:0] db);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_req_type  = rt;
    in_data_byte = db;
    do @(posedge clk); while (in_stall);
    sb.note_request(rt, db);
    @(negedge clk);
  endtask

  // random message body followed by a finish request
  task automatic send_message(input int len);
    tx_calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++)
      send_request(shabsh_pkg::REQ_ABSORB, 8'($urandom_range(0, 255)));
    send_request(shabsh_pkg::REQ_FINISH, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int len;
    int base_reqs;
    int base_msgs;
    int edge_len [6];

    edge_len     = '{55, 56, 57, 63, 64, 65};
    sb           = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_req_type  = shabsh_pkg::REQ_ABSORB;
    in_data_byte = 8'h00;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // empty message, and a finish whose data byte must be ignored
    send_request(shabsh_pkg::REQ_FINISH, 8'h00);
    send_request(shabsh_pkg::REQ_FINISH, 8'hff);
    // single byte extremes
    send_request(shabsh_pkg::REQ_ABSORB, 8'h00);
    send_request(shabsh_pkg::REQ_FINISH, 8'h00);
    send_request(shabsh_pkg::REQ_ABSORB, 8'hff);
    send_request(shabsh_pkg::REQ_FINISH, 8'hff);
    // the classic three-byte message
    send_request(shabsh_pkg::REQ_ABSORB, 8'h61);
    send_request(shabsh_pkg::REQ_ABSORB, 8'h62);
    send_request(shabsh_pkg::REQ_ABSORB, 8'h63);
    send_request(shabsh_pkg::REQ_FINISH, 8'h5a);

    // random messages, weighted towards the padding and full-block boundaries
    base_reqs = sb.requests;
    base_msgs = sb.messages;
    while (sb.requests - base_reqs < RANDOM_REQS || sb.messages - base_msgs < RANDOM_MSGS) begin
      case ($urandom_range(0, 3))
        0, 1:    len = $urandom_range(0, 8);
        2:       len = edge_len[$urandom_range(0, 5)];
        default: len = $urandom_range(9, 70);
      endcase
      send_message(len);
    end
    in_valid = 1'b0;

    // drain the owed digest words, then let the block settle
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d requests in %0d messages, %0d digest words checked",
             sb.requests, sb.messages, sb.words_checked);
    $display("message lengths spanned empty, single byte and the one and two block pad cases");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/shabsh_pkg.sv
rtl/shabsh_core.sv
rtl/sha256_byte_stream_hasher.sv
test/tb_sha256_byte_stream_hasher.sv
